>>> sv/cstd_pkg.sv
`timescale 1ns / 1ps

package cstd_pkg;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int SUM_W     = 24;
    localparam int CNT_W     = 16;
    localparam int NUM_W     = SUM_W + 1;
    localparam int SQ_W      = 2 * CH_W;
    localparam int ACC_W     = SQ_W + 1;
    localparam int DIST_W    = SQ_W + 2;
    localparam int CHAR_W    = 7;
    localparam int SEC_W     = 3;
    localparam int SYM_W     = 3;
    localparam int PAL_W     = NUM_CH * CH_W;
    localparam int PAL_DEPTH = 64;
    localparam int PAL_AW    = SEC_W + SYM_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [SEC_W-1:0] PARITY_SECTION = 3'd7;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] quot;
    } div_res_t;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] waddr;
        logic [PAL_W-1:0]  wdata;
        logic              re;
        logic [PAL_AW-1:0] raddr;
    } pal_req_t;

endpackage

>>> sv/color_symbol_text_decoder.sv
`timescale 1ns / 1ps
// Load and pixel beats are taken one per cycle with no result while the decoder is idle.
// A section-end beat holds the input stalled through three passes of the shared serial
// divider, which are skipped when the section is empty, then a palette read, a multiply
// for each colour channel and a compare per searched entry, and then the index is applied.
// After section 7 three character beats follow.
// Reset clears the sums, the pixel count and the character and parity bits at once.
module color_symbol_text_decoder #(
    parameter int MAX_PIXELS   = 65535,
    parameter int PALETTE_SIZE = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [cstd_pkg::SEC_W-1:0]  section,
    input  logic [cstd_pkg::SYM_W-1:0]  symbol,
    input  logic [cstd_pkg::CH_W-1:0]   blue,
    input  logic [cstd_pkg::CH_W-1:0]   green,
    input  logic [cstd_pkg::CH_W-1:0]   red,
    input  logic                        pixel_valid,
    input  logic                        section_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cstd_pkg::CHAR_W-1:0] character,
    output logic                        parity_bit,
    output logic                        parity_error,
    output logic                        last
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_START = 3'd1;
    localparam logic [2:0] S_DIV_WAIT  = 3'd2;
    localparam logic [2:0] S_READ      = 3'd3;
    localparam logic [2:0] S_DIST      = 3'd4;
    localparam logic [2:0] S_CMP       = 3'd5;
    localparam logic [2:0] S_APPLY     = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    localparam logic [cstd_pkg::SYM_W-1:0] LAST_SYM   = cstd_pkg::SYM_W'(PALETTE_SIZE - 1);
    localparam logic [cstd_pkg::CNT_W-1:0] MAX_COUNT  = cstd_pkg::CNT_W'(MAX_PIXELS);
    localparam logic [1:0]                 LAST_CH    = 2'd2;
    localparam logic [1:0]                 LAST_CHAR  = 2'd2;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [1:0]                    ch_reg;
    logic [cstd_pkg::SYM_W-1:0]    sym_reg;
    logic [1:0]                    out_idx_reg;
    logic [cstd_pkg::SEC_W-1:0]    sec_reg;
    logic [cstd_pkg::SUM_W-1:0]    sum_reg [cstd_pkg::NUM_CH];
    logic [cstd_pkg::CNT_W-1:0]    count_reg;
    logic [cstd_pkg::CHAR_W-1:0]   char_bits_reg [cstd_pkg::NUM_CH];
    logic [cstd_pkg::NUM_CH-1:0]   parity_reg;

    logic [cstd_pkg::CH_W-1:0]     mean_reg [cstd_pkg::NUM_CH];
    logic [cstd_pkg::SQ_W-1:0]     sq_reg;
    logic [cstd_pkg::ACC_W-1:0]    acc_reg;
    logic [cstd_pkg::DIST_W-1:0]   best_dist_reg;
    logic [cstd_pkg::SYM_W-1:0]    best_sym_reg;

    logic                          in_fire;
    logic                          out_fire;
    logic                          pixel_take;
    logic                          div_start;
    logic [cstd_pkg::NUM_W-1:0]    div_numer;
    cstd_pkg::div_res_t            div_res;
    cstd_pkg::pal_req_t            pal_req;
    logic [cstd_pkg::PAL_W-1:0]    pal_rdata;
    logic [cstd_pkg::CH_W-1:0]     pal_ch;
    logic [cstd_pkg::CH_W-1:0]     mean_ch;
    logic [cstd_pkg::CH_W-1:0]     diff;
    logic [cstd_pkg::DIST_W-1:0]   dist_total;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_valid  = (state_reg == S_OUT);
    assign out_fire   = out_valid && !out_stall;
    assign pixel_take = in_fire && kind && pixel_valid && (count_reg < MAX_COUNT);

    assign div_start = (state_reg == S_DIV_START) && (count_reg != '0);
    assign div_numer = {1'b0, sum_reg[ch_reg]}
                     + cstd_pkg::NUM_W'(count_reg >> 1);

    cstd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (count_reg),
        .res   (div_res)
    );

    always_comb
    begin
        pal_req.we    = in_fire && !kind;
        pal_req.waddr = {section, symbol};
        pal_req.wdata = {red, green, blue};
        pal_req.re    = (state_reg == S_READ);
        pal_req.raddr = {sec_reg, sym_reg};
    end

    cstd_palette u_palette (
        .clk   (clk),
        .req   (pal_req),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        case (ch_reg)
            2'd0:    pal_ch = pal_rdata[7:0];
            2'd1:    pal_ch = pal_rdata[15:8];
            default: pal_ch = pal_rdata[23:16];
        endcase
        mean_ch    = mean_reg[ch_reg];
        diff       = (pal_ch > mean_ch) ? (pal_ch - mean_ch) : (mean_ch - pal_ch);
        dist_total = cstd_pkg::DIST_W'(acc_reg) + cstd_pkg::DIST_W'(sq_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && kind && section_end)
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = (count_reg == '0) ? S_READ : S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = (ch_reg == LAST_CH) ? S_READ : S_DIV_START;
                end
            end
            S_READ:
            begin
                state_next = S_DIST;
            end
            S_DIST:
            begin
                if (ch_reg == LAST_CH)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = (sym_reg == LAST_SYM) ? S_APPLY : S_READ;
            end
            S_APPLY:
            begin
                state_next = (sec_reg == cstd_pkg::PARITY_SECTION) ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (out_fire && (out_idx_reg == LAST_CHAR))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            sym_reg     <= '0;
            out_idx_reg <= '0;
            sec_reg     <= '0;
            count_reg   <= '0;
            parity_reg  <= '0;
            for (int k = 0; k < cstd_pkg::NUM_CH; k++)
            begin
                sum_reg[k]       <= '0;
                char_bits_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pixel_take)
            begin
                sum_reg[0] <= sum_reg[0] + cstd_pkg::SUM_W'(blue);
                sum_reg[1] <= sum_reg[1] + cstd_pkg::SUM_W'(green);
                sum_reg[2] <= sum_reg[2] + cstd_pkg::SUM_W'(red);
                count_reg  <= count_reg + 1'b1;
            end
            if (in_fire && kind && section_end)
            begin
                sec_reg <= section;
                ch_reg  <= '0;
                sym_reg <= '0;
            end
            case (state_reg)
                S_DIV_START:
                begin
                    if (count_reg == '0)
                    begin
                        ch_reg <= '0;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_res.done)
                    begin
                        ch_reg <= (ch_reg == LAST_CH) ? 2'd0 : ch_reg + 1'b1;
                    end
                end
                S_DIST:
                begin
                    ch_reg <= (ch_reg == LAST_CH) ? 2'd0 : ch_reg + 1'b1;
                end
                S_CMP:
                begin
                    sym_reg <= sym_reg + 1'b1;
                end
                S_APPLY:
                begin
                    count_reg   <= '0;
                    out_idx_reg <= '0;
                    for (int k = 0; k < cstd_pkg::NUM_CH; k++)
                    begin
                        sum_reg[k] <= '0;
                    end
                    if (sec_reg == cstd_pkg::PARITY_SECTION)
                    begin
                        parity_reg <= best_sym_reg;
                    end
                    else
                    begin
                        for (int k = 0; k < cstd_pkg::NUM_CH; k++)
                        begin
                            if (best_sym_reg[k])
                            begin
                                char_bits_reg[k][sec_reg] <= 1'b1;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == LAST_CHAR)
                        begin
                            parity_reg <= '0;
                            for (int k = 0; k < cstd_pkg::NUM_CH; k++)
                            begin
                                char_bits_reg[k] <= '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DIV_START) && (count_reg == '0))
        begin
            for (int k = 0; k < cstd_pkg::NUM_CH; k++)
            begin
                mean_reg[k] <= '0;
            end
        end
        if ((state_reg == S_DIV_WAIT) && div_res.done)
        begin
            mean_reg[ch_reg] <= div_res.quot;
        end
        if (state_reg == S_DIST)
        begin
            sq_reg  <= diff * diff;
            acc_reg <= (ch_reg == 2'd0) ? '0 : acc_reg + cstd_pkg::ACC_W'(sq_reg);
        end
        if (state_reg == S_CMP)
        begin
            if ((sym_reg == '0) || (dist_total < best_dist_reg))
            begin
                best_dist_reg <= dist_total;
                best_sym_reg  <= sym_reg;
            end
        end
    end

    assign character    = char_bits_reg[out_idx_reg];
    assign parity_bit   = parity_reg[out_idx_reg];
    assign parity_error = (^char_bits_reg[out_idx_reg]) ^ parity_reg[out_idx_reg];
    assign last         = (out_idx_reg == LAST_CHAR);

    // A result beat is only ever offered while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result offered while input accepted");

    // The divider reports completion only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider completion outside wait state");

    // The pixel count saturates and never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= MAX_COUNT)
        else $error("pixel count beyond limit");

    // Once the third character is taken, the frame's bits are cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last) |=> ((char_bits_reg[0] == '0) && (char_bits_reg[1] == '0)
                               && (char_bits_reg[2] == '0) && (parity_reg == '0)))
        else $error("character bits not cleared after frame");

endmodule

>>> sv/cstd_div.sv
`timescale 1ns / 1ps

module cstd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cstd_pkg::NUM_W-1:0]  numer,
    input  logic [cstd_pkg::CNT_W-1:0]  denom,
    output cstd_pkg::div_res_t          res
);

    logic [cstd_pkg::NUM_W-1:0]     num_reg;
    logic [cstd_pkg::CNT_W-1:0]     den_reg;
    logic [cstd_pkg::CNT_W-1:0]     rem_reg;
    logic [cstd_pkg::CH_W-1:0]      quot_reg;
    logic [cstd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [cstd_pkg::CNT_W:0]       rem_shift;
    logic                           fits;
    logic [cstd_pkg::CNT_W:0]       rem_sub;

    assign rem_shift = {rem_reg, num_reg[cstd_pkg::NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cstd_pkg::DIV_CNT_W'(cstd_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == cstd_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= numer;
            den_reg  <= denom;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[cstd_pkg::NUM_W-2:0], 1'b0};
            rem_reg  <= fits ? rem_sub[cstd_pkg::CNT_W-1:0] : rem_shift[cstd_pkg::CNT_W-1:0];
            quot_reg <= {quot_reg[cstd_pkg::CH_W-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

>>> sv/cstd_palette.sv
`timescale 1ns / 1ps

module cstd_palette (
    input  logic                       clk,
    input  cstd_pkg::pal_req_t         req,
    output logic [cstd_pkg::PAL_W-1:0] rdata
);

    logic [cstd_pkg::PAL_W-1:0] mem [cstd_pkg::PAL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MAX_PIXELS   = 24;
    localparam int PALETTE_SIZE = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 150;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct {
        logic                       kind;
        logic [cstd_pkg::SEC_W-1:0] section;
        logic [cstd_pkg::SYM_W-1:0] symbol;
        logic [cstd_pkg::PAL_W-1:0] colour;
        logic                       pixel_valid;
        logic                       section_end;
    } beat_t;

    typedef struct {
        logic [cstd_pkg::CHAR_W-1:0] character;
        logic                        parity_bit;
        logic                        parity_error;
        logic                        last;
    } char_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic                         kind         = 1'b0;
    logic [cstd_pkg::SEC_W-1:0]   section      = '0;
    logic [cstd_pkg::SYM_W-1:0]   symbol       = '0;
    logic [cstd_pkg::CH_W-1:0]    blue         = '0;
    logic [cstd_pkg::CH_W-1:0]    green        = '0;
    logic [cstd_pkg::CH_W-1:0]    red          = '0;
    logic                         pixel_valid  = 1'b0;
    logic                         section_end  = 1'b0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic [cstd_pkg::CHAR_W-1:0]  character;
    logic                         parity_bit;
    logic                         parity_error;
    logic                         last;

    beat_t                        beat_queue[$];
    char_t                        char_queue[$];
    beat_t                        current;
    logic                         in_taken     = 1'b0;

    logic [cstd_pkg::PAL_W-1:0]   planned_palette [cstd_pkg::PAL_DEPTH];
    logic [cstd_pkg::PAL_W-1:0]   palette_mem [cstd_pkg::PAL_DEPTH];
    logic [cstd_pkg::SUM_W-1:0]   chan_sum [cstd_pkg::NUM_CH];
    logic [cstd_pkg::CNT_W-1:0]   pix_count;
    logic [cstd_pkg::CHAR_W-1:0]  char_acc [3];

    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  items_planned   = 0;
    int                  results_planned = 0;
    int                  beats_taken     = 0;
    int                  chars_checked   = 0;
    int                  mismatches      = 0;
    int                  cycle_count     = 0;

    color_symbol_text_decoder #(
        .MAX_PIXELS   (MAX_PIXELS),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .section      (section),
        .symbol       (symbol),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .pixel_valid  (pixel_valid),
        .section_end  (section_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .character    (character),
        .parity_bit   (parity_bit),
        .parity_error (parity_error),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic beat_t make_beat(input logic k, input logic [cstd_pkg::SEC_W-1:0] sec,
                                        input logic [cstd_pkg::SYM_W-1:0] sym,
                                        input logic [cstd_pkg::PAL_W-1:0] colour,
                                        input logic pv, input logic se);
        beat_t b;
        b.kind        = k;
        b.section     = sec;
        b.symbol      = sym;
        b.colour      = colour;
        b.pixel_valid = pv;
        b.section_end = se;
        return b;
    endfunction

    function automatic logic [cstd_pkg::PAL_W-1:0] near_colour(
        input logic [cstd_pkg::PAL_W-1:0] c, input int spread);
        logic [cstd_pkg::PAL_W-1:0] r;
        int                         v;
        for (int ch = 0; ch < cstd_pkg::NUM_CH; ch++)
        begin
            v = int'(c[8*ch +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            r[8*ch +: 8] = v[7:0];
        end
        return r;
    endfunction

    task automatic queue_beat(input beat_t b);
        beat_queue = {beat_queue, b};
        items_planned++;
    endtask

    task automatic queue_load(input logic [cstd_pkg::SEC_W-1:0] sec,
                              input logic [cstd_pkg::SYM_W-1:0] sym,
                              input logic [cstd_pkg::PAL_W-1:0] colour, input logic pv,
                              input logic se);
        planned_palette[{sec, sym}] = colour;
        queue_beat(make_beat(KIND_LOAD, sec, sym, colour, pv, se));
    endtask

    // Pixels carry the tag given; the closing beat carries the section that is decoded.
    task automatic queue_section(input logic [cstd_pkg::SEC_W-1:0] sec,
                                 input logic [cstd_pkg::SEC_W-1:0] tag,
                                 input int n, input logic [cstd_pkg::PAL_W-1:0] target,
                                 input int spread, input logic end_pixel);
        for (int i = 0; i < n; i++)
            queue_beat(make_beat(KIND_PIXEL, tag, cstd_pkg::SYM_W'($urandom),
                                 near_colour(target, spread), 1'b1, 1'b0));
        queue_beat(make_beat(KIND_PIXEL, sec, cstd_pkg::SYM_W'($urandom),
                             near_colour(target, spread), end_pixel, 1'b1));
        if (sec == cstd_pkg::PARITY_SECTION)
            results_planned += 3;
    endtask

    task automatic decode_beat(input beat_t b);
        int unsigned                mean [cstd_pkg::NUM_CH];
        int unsigned                best_dist;
        int unsigned                sq_sum;
        int                         d;
        logic [cstd_pkg::PAL_W-1:0] entry;
        logic [cstd_pkg::SYM_W-1:0] idx;
        char_t                      c;
        if (b.kind == KIND_LOAD)
        begin
            palette_mem[{b.section, b.symbol}] = b.colour;
            return;
        end
        if (b.pixel_valid && pix_count < MAX_PIXELS)
        begin
            for (int k = 0; k < cstd_pkg::NUM_CH; k++)
                chan_sum[k] = chan_sum[k] + cstd_pkg::SUM_W'(b.colour[8*k +: 8]);
            pix_count = pix_count + 1'b1;
        end
        if (!b.section_end)
            return;
        for (int k = 0; k < cstd_pkg::NUM_CH; k++)
        begin
            if (pix_count == 0)
                mean[k] = 0;
            else
                mean[k] = ((32'(chan_sum[k]) + 32'(pix_count) / 2) / 32'(pix_count)) % 256;
        end
        idx       = '0;
        best_dist = 32'hFFFF_FFFF;
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            entry  = palette_mem[{b.section, cstd_pkg::SYM_W'(i)}];
            sq_sum = 0;
            for (int ch = 0; ch < cstd_pkg::NUM_CH; ch++)
            begin
                d      = int'(entry[8*ch +: 8]) - int'(mean[ch]);
                sq_sum = sq_sum + d * d;
            end
            if (sq_sum < best_dist)
            begin
                best_dist = sq_sum;
                idx       = cstd_pkg::SYM_W'(i);
            end
        end
        for (int k = 0; k < cstd_pkg::NUM_CH; k++)
            chan_sum[k] = '0;
        pix_count = '0;
        if (b.section != cstd_pkg::PARITY_SECTION)
        begin
            for (int k = 0; k < 3; k++)
                if (idx[k])
                    char_acc[k][b.section] = 1'b1;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                c.character    = char_acc[k];
                c.parity_bit   = idx[k];
                c.parity_error = ^char_acc[k] ^ idx[k];
                c.last         = (k == 2);
                char_queue     = {char_queue, c};
                char_acc[k] = '0;
            end
        end
    endtask

    task automatic wait_drained();
        while (beat_queue.size() != 0 || in_valid || char_queue.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            decode_beat(current);
            beats_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (beat_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                current = beat_queue.pop_front();
                kind        <= current.kind;
                section     <= current.section;
                symbol      <= current.symbol;
                blue        <= current.colour[7:0];
                green       <= current.colour[15:8];
                red         <= current.colour[23:16];
                pixel_valid <= current.pixel_valid;
                section_end <= current.section_end;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (char_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected character %h parity %b error %b last %b",
                             character, parity_bit, parity_error, last);
            end
            else
            begin
                want = char_queue.pop_front();
                chars_checked++;
                if (character !== want.character || parity_bit !== want.parity_bit ||
                    parity_error !== want.parity_error || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                 want.character, want.parity_bit, want.parity_error,
                                 want.last, character, parity_bit, parity_error, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, char_queue.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int                         idle_tab [4];
        int                         stall_tab [4];
        int                         item_start;
        int                         result_start;
        int                         n;
        int                         spread;
        int                         reps;
        logic [cstd_pkg::SEC_W-1:0] sec;
        logic [cstd_pkg::SEC_W-1:0] tag;
        logic [cstd_pkg::PAL_W-1:0] target;

        idle_tab  = '{0, 55, 0, 14};
        stall_tab = '{0, 0, 55, 14};
        for (int k = 0; k < cstd_pkg::NUM_CH; k++)
            chan_sum[k] = '0;
        pix_count = '0;
        for (int k = 0; k < 3; k++)
            char_acc[k] = '0;

        // Every palette entry is written before any section can be decoded.
        for (int i = 0; i < cstd_pkg::PAL_DEPTH; i++)
            queue_load(cstd_pkg::SEC_W'(i >> 3), cstd_pkg::SYM_W'(i),
                       cstd_pkg::PAL_W'($urandom), 1'b0, 1'b0);
        queue_load(3'd0, 3'd0, 24'h000000, 1'b0, 1'b0);
        queue_load(3'd7, 3'd7, 24'hFFFFFF, 1'b0, 1'b0);

        queue_load(3'd3, 3'd2, 24'hFFFFFF, 1'b1, 1'b1);
        queue_load(3'd3, 3'd5, 24'hFFFFFF, 1'b1, 1'b0);
        queue_section(3'd0, 3'd0, 0, 24'h000000, 0, 1'b0);
        queue_section(3'd1, 3'd6, 2, planned_palette[{3'd1, 3'd3}], 0, 1'b1);
        queue_section(3'd3, 3'd3, 2, 24'hFFFFFF, 0, 1'b0);
        queue_beat(make_beat(KIND_PIXEL, 3'd4, 3'd7, 24'h000000, 1'b1, 1'b0));
        queue_section(3'd4, 3'd4, 0, 24'hFFFFFF, 0, 1'b1);
        queue_section(3'd5, 3'd5, 1, planned_palette[{3'd5, 3'd1}], 0, 1'b0);
        queue_section(3'd5, 3'd5, 1, planned_palette[{3'd5, 3'd6}], 0, 1'b0);
        queue_beat(make_beat(KIND_PIXEL, 3'd6, 3'd0, 24'h5A5A5A, 1'b0, 1'b0));
        queue_section(3'd6, 3'd6, 1, planned_palette[{3'd6, 3'd4}], 0, 1'b1);
        queue_section(3'd7, 3'd7, 1, 24'hFFFFFF, 0, 1'b0);

        // The count must hold at its ceiling, so the black beats at the tail are dropped.
        for (int i = 0; i < MAX_PIXELS; i++)
            queue_beat(make_beat(KIND_PIXEL, 3'd2, 3'd0, planned_palette[{3'd2, 3'd4}],
                                 1'b1, 1'b0));
        queue_section(3'd2, 3'd2, 5, 24'h000000, 0, 1'b0);
        queue_section(cstd_pkg::PARITY_SECTION, cstd_pkg::PARITY_SECTION, 0, 24'h000000, 0,
                      1'b0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_tab[phase];
            recv_stall_pct = stall_tab[phase];
            item_start     = items_planned;
            result_start   = results_planned;
            while (items_planned - item_start < 100 || results_planned - result_start < 12)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 10))
                    begin
                        sec = cstd_pkg::SEC_W'($urandom);
                        queue_section(sec, sec, $urandom_range(0, 4),
                                      cstd_pkg::PAL_W'($urandom), 127, 1'($urandom));
                    end
                end
                else
                begin
                    for (int s = 0; s < 8; s++)
                    begin
                        if (s != cstd_pkg::PARITY_SECTION && $urandom_range(0, 9) == 0)
                            continue;
                        reps = ($urandom_range(0, 9) == 0) ? 2 : 1;
                        repeat (reps)
                        begin
                            if ($urandom_range(0, 11) == 0)
                                queue_load(cstd_pkg::SEC_W'($urandom),
                                           cstd_pkg::SYM_W'($urandom),
                                           cstd_pkg::PAL_W'($urandom), 1'($urandom),
                                           1'($urandom));
                            if ($urandom_range(0, 11) == 0)
                                queue_beat(make_beat(KIND_PIXEL, cstd_pkg::SEC_W'($urandom),
                                                     cstd_pkg::SYM_W'($urandom),
                                                     cstd_pkg::PAL_W'($urandom),
                                                     1'b0, 1'b0));
                            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                            : $urandom_range(0, 4);
                            tag = ($urandom_range(0, 6) == 0) ? cstd_pkg::SEC_W'($urandom)
                                                              : cstd_pkg::SEC_W'(s);
                            if ($urandom_range(0, 9) < 7)
                            begin
                                target = planned_palette[{cstd_pkg::SEC_W'(s),
                                                          cstd_pkg::SYM_W'($urandom)}];
                                spread = $urandom_range(0, 12);
                            end
                            else
                            begin
                                target = cstd_pkg::PAL_W'($urandom);
                                spread = 40;
                            end
                            queue_section(cstd_pkg::SEC_W'(s), tag, n, target, spread,
                                          1'($urandom));
                        end
                    end
                end
            end
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        mismatches += char_queue.size();
        $display("tb: %0d beats accepted, %0d characters checked, %0d mismatches",
                 beats_taken, chars_checked, mismatches);
        $display("tb: covered palette ties, empty, repeated and missing sections, %s",
                 "a saturated count and four stall mixes");
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
